// ===== rtl/core/bfst_pkg.sv =====
package bfst_pkg;

   // Widths of the transaction fields.
   localparam int FIELD_BITS = 32;

   // Defaults for the top-level parameters.
   localparam int DEPTH_DEFAULT     = 16;
   localparam int ADDR_BITS_DEFAULT = 32;

   typedef enum logic [1:0] {
      OP_ADD      = 2'd0,
      OP_FIND     = 2'd1,
      OP_BEST_FIT = 2'd2,
      OP_REMOVE   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SCAN,
      ST_SHIFT,
      ST_DONE
   } state_type;

   typedef struct packed {
      op_type                  op;
      logic [FIELD_BITS-1:0]   seg_address;
      logic [FIELD_BITS-1:0]   seg_size;
   } req_type;

   typedef struct packed {
      logic                    found;
      logic [FIELD_BITS-1:0]   result_address;
      logic [FIELD_BITS-1:0]   result_size;
      logic                    table_full;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start;
      logic add;
      logic scan_init;
      logic scan;
      logic shift_init;
      logic shift;
      logic count_dec;
      logic rsp_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      op_type op;
      logic   count_zero;
      logic   match;
      logic   last;
      logic   shift_done;
   } status_type;

endpackage

// ===== rtl/core/best_fit_segment_table.sv =====
// Best-fit free segment table. The block keeps up to DEPTH free segments, each a start
// address and a size, in age order, and answers one operation per request transaction:
// add pushes a segment as the newest entry (or reports table_full when DEPTH entries are
// held), find returns the newest entry with a given address, best fit returns the smallest
// segment at least the requested size (the newest wins among equal sizes), and remove
// deletes the newest entry with a given address and closes the gap. Every request gives
// exactly one response transaction. Addresses are kept to ADDR_BITS bits. The block works
// on one request at a time. A find or best fit scans the table through the segment memory,
// which has one registered read port and delivers one entry per cycle. A find or remove
// stops its scan at the first match. A remove that hits then runs a compaction pass
// through the same memory port, which moves every entry newer than the removed one down
// by one place. The response sits in an output register, so the next request is accepted
// while an earlier response is still stalled.
module best_fit_segment_table #(
   parameter int DEPTH     = bfst_pkg::DEPTH_DEFAULT,
   parameter int ADDR_BITS = bfst_pkg::ADDR_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,

   // Request channel: a transaction completes when req_valid is high and req_stall low.
   input  logic                req_valid,
   output logic                req_stall,
   input  bfst_pkg::req_type   req_payload,

   // Response channel: a transaction completes when rsp_valid is high and rsp_stall low.
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output bfst_pkg::rsp_type   rsp_payload
);

   // The controller sequences each operation; the datapath holds the segment memory,
   // the entry count, the scan and compaction indexes, and the result registers.
   bfst_pkg::cmd_type    cmd;
   bfst_pkg::status_type status;

   bfst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // The scan runs from the newest entry down to the oldest, so the first address match
   // is the newest one, and a strict size compare keeps the newest among equal sizes.
   bfst_datapath #(
      .DEPTH     (DEPTH),
      .ADDR_BITS (ADDR_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

// ===== rtl/core/bfst_ctrl.sv =====
module bfst_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  bfst_pkg::status_type   status,
   output bfst_pkg::cmd_type      cmd
);

   bfst_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                lookup_op;

   assign lookup_op = status.op inside {bfst_pkg::OP_FIND, bfst_pkg::OP_REMOVE};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bfst_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bfst_pkg::ST_IDLE: begin
            if (req_valid) state_in = bfst_pkg::ST_DISPATCH;
         end
         bfst_pkg::ST_DISPATCH: begin
            if (status.op == bfst_pkg::OP_ADD || status.count_zero) begin
               state_in = bfst_pkg::ST_DONE;
            end else begin
               state_in = bfst_pkg::ST_SCAN;
            end
         end
         bfst_pkg::ST_SCAN: begin
            if (status.match && lookup_op) begin
               state_in = (status.op == bfst_pkg::OP_REMOVE) ? bfst_pkg::ST_SHIFT
                                                             : bfst_pkg::ST_DONE;
            end else if (status.last) begin
               state_in = bfst_pkg::ST_DONE;
            end
         end
         bfst_pkg::ST_SHIFT: begin
            if (status.shift_done) state_in = bfst_pkg::ST_DONE;
         end
         bfst_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = bfst_pkg::ST_IDLE;
         end
         default: state_in = bfst_pkg::ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd = '0;
      req_stall = 1'b1;
      case (state_ff)
         bfst_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.start = req_valid;
         end
         bfst_pkg::ST_DISPATCH: begin
            if (status.op == bfst_pkg::OP_ADD) begin
               cmd.add = 1'b1;
            end else if (!status.count_zero) begin
               cmd.scan_init = 1'b1;
            end
         end
         bfst_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
            cmd.shift_init = status.match && (status.op == bfst_pkg::OP_REMOVE);
         end
         bfst_pkg::ST_SHIFT: begin
            cmd.shift = 1'b1;
            cmd.count_dec = status.shift_done;
         end
         bfst_pkg::ST_DONE: begin
            cmd.rsp_load = !rsp_valid_ff || !rsp_stall;
         end
         default: cmd = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/core/bfst_datapath.sv =====
module bfst_datapath #(
   parameter int DEPTH     = bfst_pkg::DEPTH_DEFAULT,
   parameter int ADDR_BITS = bfst_pkg::ADDR_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  bfst_pkg::req_type      req_payload,
   output bfst_pkg::rsp_type      rsp_payload,
   input  bfst_pkg::cmd_type      cmd,
   output bfst_pkg::status_type   status
);

   localparam int FB = bfst_pkg::FIELD_BITS;
   localparam int AW = (ADDR_BITS < FB) ? ADDR_BITS : FB;
   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   // Segment store: one write port and one registered read port.
   logic [AW-1:0]  mem_addr_ff [DEPTH];
   logic [FB-1:0]  mem_size_ff [DEPTH];
   logic [AW-1:0]  rd_addr_ff;
   logic [FB-1:0]  rd_size_ff;

   logic [CW-1:0]  count_ff, count_in;
   logic [CW-1:0]  idx_ff, idx_in;
   logic [CW-1:0]  data_idx_ff, data_idx_in;
   logic           data_vld_ff, data_vld_in;
   logic           issued_all_ff, issued_all_in;

   bfst_pkg::op_type op_ff, op_in;
   logic [AW-1:0]  key_addr_ff, key_addr_in;
   logic [FB-1:0]  key_size_ff, key_size_in;

   bfst_pkg::rsp_type res_ff, res_in;
   bfst_pkg::rsp_type out_ff, out_in;

   logic           full;
   logic           match;
   logic           fits;
   logic           rd_en;
   logic           wr_en;
   logic [IW-1:0]  wr_idx;
   logic [CW-1:0]  below_idx;
   logic [AW-1:0]  wr_addr;
   logic [FB-1:0]  wr_size;

   assign full      = (count_ff == CW'(DEPTH));
   assign match     = data_vld_ff && (rd_addr_ff == key_addr_ff);
   assign fits      = (rd_size_ff >= key_size_ff) &&
                      (!res_ff.found || (rd_size_ff < res_ff.result_size));
   assign below_idx = data_idx_ff - CW'(1);

   assign rd_en = (cmd.scan && !issued_all_ff) || (cmd.shift && (idx_ff < count_ff));
   assign wr_en = (cmd.add && !full) || (cmd.shift && data_vld_ff);

   always_comb begin
      if (cmd.add) begin
         wr_idx  = count_ff[IW-1:0];
         wr_addr = key_addr_ff;
         wr_size = key_size_ff;
      end else begin
         wr_idx  = below_idx[IW-1:0];
         wr_addr = rd_addr_ff;
         wr_size = rd_size_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_addr_ff[wr_idx] <= wr_addr;
         mem_size_ff[wr_idx] <= wr_size;
      end
      if (rd_en) begin
         rd_addr_ff <= mem_addr_ff[idx_ff[IW-1:0]];
         rd_size_ff <= mem_size_ff[idx_ff[IW-1:0]];
      end
   end

   always_comb begin
      count_in      = count_ff;
      idx_in        = idx_ff;
      issued_all_in = issued_all_ff;
      data_vld_in   = rd_en && !cmd.shift_init;
      data_idx_in   = rd_en ? idx_ff : data_idx_ff;
      op_in         = op_ff;
      key_addr_in   = key_addr_ff;
      key_size_in   = key_size_ff;
      res_in        = res_ff;
      out_in        = out_ff;

      if (cmd.start) begin
         op_in       = req_payload.op;
         key_addr_in = req_payload.seg_address[AW-1:0];
         key_size_in = req_payload.seg_size;
         res_in      = '0;
      end

      if (cmd.add) begin
         if (full) begin
            res_in.table_full = 1'b1;
         end else begin
            count_in              = count_ff + CW'(1);
            res_in.found          = 1'b1;
            res_in.result_address = FB'(key_addr_ff);
            res_in.result_size    = key_size_ff;
         end
      end

      if (cmd.scan_init) begin
         idx_in        = count_ff - CW'(1);
         issued_all_in = 1'b0;
      end

      if (cmd.scan) begin
         if (rd_en) begin
            idx_in = idx_ff - CW'(1);
            if (idx_ff == '0) issued_all_in = 1'b1;
         end
         if (op_ff == bfst_pkg::OP_BEST_FIT) begin
            if (data_vld_ff && fits) begin
               res_in.found          = 1'b1;
               res_in.result_address = FB'(rd_addr_ff);
               res_in.result_size    = rd_size_ff;
            end
         end else if (match) begin
            res_in.found          = 1'b1;
            res_in.result_address = FB'(rd_addr_ff);
            res_in.result_size    = rd_size_ff;
         end
      end

      // Compaction starts at the entry just above the removed one.
      if (cmd.shift_init) begin
         idx_in = data_idx_ff + CW'(1);
      end

      if (cmd.shift && rd_en) begin
         idx_in = idx_ff + CW'(1);
      end

      if (cmd.count_dec) begin
         count_in = count_ff - CW'(1);
      end

      if (cmd.rsp_load) begin
         out_in = res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         data_vld_ff   <= 1'b0;
         issued_all_ff <= 1'b1;
      end else begin
         count_ff      <= count_in;
         data_vld_ff   <= data_vld_in;
         issued_all_ff <= issued_all_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      data_idx_ff <= data_idx_in;
      op_ff       <= op_in;
      key_addr_ff <= key_addr_in;
      key_size_ff <= key_size_in;
      res_ff      <= res_in;
      out_ff      <= out_in;
   end

   assign status.op         = op_ff;
   assign status.count_zero = (count_ff == '0);
   assign status.match      = match;
   assign status.last       = data_vld_ff && (data_idx_ff == '0);
   assign status.shift_done = (idx_ff >= count_ff) && !data_vld_ff;

   assign rsp_payload = out_ff;

endmodule

// ===== bench/tb_best_fit_segment_table.sv =====
`timescale 1ns / 1ps

module tb_best_fit_segment_table;
   import bfst_pkg::*;

   localparam int TABLE_DEPTH = DEPTH_DEFAULT;
   localparam int ADDR_WIDTH  = ADDR_BITS_DEFAULT;

   // Instruction mixes used by the random phases of the run.
   typedef enum int {
      MIX_FILL,
      MIX_MIXED,
      MIX_DRAIN
   } mix_kind;

   // Shadow copy of the segment table. Every accepted request transaction is applied to
   // it in order, and the answer the block should give is queued for the response side.
   class segment_ledger;
      logic [FIELD_BITS-1:0] held_addr [TABLE_DEPTH];
      logic [FIELD_BITS-1:0] held_size [TABLE_DEPTH];
      int held_count;
      rsp_type awaited_answers [$];
      int failures;

      function new();
         held_count = 0;
         failures = 0;
      endfunction

      // Position of the newest entry with this address, or -1.
      function int newest_with_address(logic [FIELD_BITS-1:0] addr);
         int k;
         for (k = held_count - 1; k >= 0; k--) begin
            if (held_addr[k] == addr) return k;
         end
         return -1;
      endfunction

      function void note_request(req_type req);
         rsp_type ans;
         int pos;
         int k;
         int best;
         bit have;
         ans = '0;
         case (req.op)
            OP_ADD: begin
               if (held_count >= TABLE_DEPTH) begin
                  ans.table_full = 1'b1;
               end else begin
                  held_addr[held_count] = req.seg_address;
                  held_size[held_count] = req.seg_size;
                  held_count++;
                  ans.found = 1'b1;
                  ans.result_address = req.seg_address;
                  ans.result_size = req.seg_size;
               end
            end
            OP_FIND: begin
               pos = newest_with_address(req.seg_address);
               if (pos >= 0) begin
                  ans.found = 1'b1;
                  ans.result_address = held_addr[pos];
                  ans.result_size = held_size[pos];
               end
            end
            OP_BEST_FIT: begin
               have = 1'b0;
               best = 0;
               for (k = held_count - 1; k >= 0; k--) begin
                  if (held_size[k] >= req.seg_size &&
                      (!have || held_size[k] < held_size[best])) begin
                     best = k;
                     have = 1'b1;
                  end
               end
               if (have) begin
                  ans.found = 1'b1;
                  ans.result_address = held_addr[best];
                  ans.result_size = held_size[best];
               end
            end
            default: begin
               pos = newest_with_address(req.seg_address);
               if (pos >= 0) begin
                  ans.found = 1'b1;
                  ans.result_address = held_addr[pos];
                  ans.result_size = held_size[pos];
                  for (k = pos; k + 1 < held_count; k++) begin
                     held_addr[k] = held_addr[k + 1];
                     held_size[k] = held_size[k + 1];
                  end
                  held_count--;
               end
            end
         endcase
         awaited_answers.push_back(ans);
      endfunction

      function void check_answer(rsp_type got);
         rsp_type want;
         if (awaited_answers.size() == 0) begin
            $error("response transaction %h arrived with no request outstanding", got);
            failures++;
            return;
         end
         want = awaited_answers.pop_front();
         if (got.found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, got.found);
            failures++;
         end
         if (got.result_address !== want.result_address) begin
            $error("result_address: expected %h, actual %h",
                   want.result_address, got.result_address);
            failures++;
         end
         if (got.result_size !== want.result_size) begin
            $error("result_size: expected %h, actual %h", want.result_size, got.result_size);
            failures++;
         end
         if (got.table_full !== want.table_full) begin
            $error("table_full: expected %0d, actual %0d", want.table_full, got.table_full);
            failures++;
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   segment_ledger ledger = new();

   // When idle_on is clear, neither side inserts gaps or stalls. A nonzero hold_request
   // tells the response side to stall for that many cycles in one stretch.
   bit idle_on = 1'b1;
   int hold_request = 0;

   // A handful of recurring addresses, so that duplicates and hits happen often.
   logic [FIELD_BITS-1:0] address_pool [8];

   best_fit_segment_table #(
      .DEPTH     (TABLE_DEPTH),
      .ADDR_BITS (ADDR_WIDTH)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Most pauses are zero or a few cycles; now and then a long one falls in.
   function automatic int pick_pause();
      int r;
      if (!idle_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Addresses for find and remove lean towards entries that are really held, while
   // addresses for add lean towards the pool and fresh random values.
   function automatic logic [FIELD_BITS-1:0] some_address(bit favor_held);
      int r;
      int held_cut;
      int pool_cut;
      r = $urandom_range(0, 99);
      held_cut = favor_held ? 60 : 20;
      pool_cut = favor_held ? 80 : 50;
      if (ledger.held_count > 0 && r < held_cut) begin
         return ledger.held_addr[$urandom_range(0, ledger.held_count - 1)];
      end
      if (r < pool_cut) return address_pool[$urandom_range(0, 7)];
      return $urandom;
   endfunction

   // Sizes mix small values, copies of held sizes (ties for best fit), one above a held
   // size (just misses it) and the extremes of the field.
   function automatic logic [FIELD_BITS-1:0] some_size(bit for_fit);
      int r;
      logic [FIELD_BITS-1:0] s;
      r = $urandom_range(0, 99);
      if (ledger.held_count > 0 && r < 30) begin
         s = ledger.held_size[$urandom_range(0, ledger.held_count - 1)];
         return (for_fit && r < 10) ? s + 1 : s;
      end
      if (r < 65) return $urandom_range(0, 20);
      if (r < 70) return for_fit ? '0 : '1;
      return $urandom;
   endfunction

   function automatic req_type random_request(mix_kind mix);
      req_type req;
      int w;
      int add_cut;
      int find_cut;
      int fit_cut;
      case (mix)
         MIX_FILL: begin
            add_cut = 60; find_cut = 75; fit_cut = 90;
         end
         MIX_MIXED: begin
            add_cut = 30; find_cut = 50; fit_cut = 75;
         end
         default: begin
            add_cut = 15; find_cut = 35; fit_cut = 55;
         end
      endcase
      w = $urandom_range(0, 99);
      if (w < add_cut) begin
         req.op = OP_ADD;
         req.seg_address = some_address(1'b0);
         req.seg_size = some_size(1'b0);
      end else if (w < find_cut) begin
         req.op = OP_FIND;
         req.seg_address = some_address(1'b1);
         req.seg_size = $urandom;
      end else if (w < fit_cut) begin
         req.op = OP_BEST_FIT;
         req.seg_address = $urandom;
         req.seg_size = some_size(1'b1);
      end else begin
         req.op = OP_REMOVE;
         req.seg_address = some_address(1'b1);
         req.seg_size = $urandom;
      end
      return req;
   endfunction

   // Offers one request transaction after a gap of the given number of cycles. The
   // payload changes only at a falling edge, and the handshake is sampled at the rising
   // edge, so the transaction is noted in the ledger exactly when the block takes it.
   task automatic send_request(input req_type req, input int gap);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_payload <= req;
      do @(posedge clock); while (req_stall);
      ledger.note_request(req);
   endtask

   task automatic issue(input op_type op, input logic [FIELD_BITS-1:0] addr,
                        input logic [FIELD_BITS-1:0] size);
      req_type req;
      req.op = op;
      req.seg_address = addr;
      req.seg_size = size;
      send_request(req, pick_pause());
   endtask

   // Drops valid and waits until every outstanding response transaction has been checked.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (ledger.awaited_answers.size() != 0) @(posedge clock);
   endtask

   // Response side. The stall decision is made at the falling edge and the handshake is
   // checked at the next rising edge. A pending hold request overrides the random pattern
   // and is counted down here, one cycle per loop.
   initial begin : response_side
      int stall_left;
      stall_left = 0;
      wait (reset == 1'b0);
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            stall_left = hold_request;
            hold_request = 0;
         end else if (stall_left == 0 && idle_on && $urandom_range(0, 3) == 0) begin
            stall_left = pick_pause();
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
         @(posedge clock);
         if (rsp_valid && !rsp_stall) ledger.check_answer(rsp_payload);
      end
   end

   initial begin : stimulus
      int i;
      int p;
      address_pool[0] = '0;
      address_pool[1] = '1;
      for (i = 2; i < 8; i++) address_pool[i] = $urandom;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part. Operations on the empty table must all miss.
      issue(OP_BEST_FIT, 32'h0000_0000, 32'h0000_0000);
      issue(OP_REMOVE, 32'h0000_1000, 32'h0000_0000);

      // Field extremes, a zero size, two entries of equal size and a duplicate address.
      issue(OP_ADD, 32'h0000_0000, 32'h0000_0000);
      issue(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      issue(OP_ADD, 32'h0000_1000, 32'd100);
      issue(OP_ADD, 32'h0000_3000, 32'd100);
      issue(OP_ADD, 32'h0000_2000, 32'd50);
      issue(OP_ADD, 32'h0000_1000, 32'd7);

      // Fill the table to the brim, then one add that must be refused.
      for (i = 0; i < TABLE_DEPTH - 6; i++) issue(OP_ADD, 32'h0000_5000 + i * 16, 200 + i);
      issue(OP_ADD, 32'hA5A5_5A5A, 32'd1);

      // Best fit for size zero fits anything; for 60 the newer of the two equal
      // entries must win; for the largest size only the largest entry fits.
      issue(OP_BEST_FIT, 32'h0000_0000, 32'd0);
      issue(OP_BEST_FIT, 32'h0000_0000, 32'd60);
      issue(OP_BEST_FIT, 32'h0000_0000, 32'hFFFF_FFFF);

      // Find and remove act on the newest entry of a duplicated address, and a removal
      // from the middle of a full table closes the gap.
      issue(OP_FIND, 32'h0000_1000, 32'd0);
      issue(OP_REMOVE, 32'h0000_1000, 32'd0);
      issue(OP_REMOVE, 32'hFFFF_FFFF, 32'd0);
      issue(OP_BEST_FIT, 32'h0000_0000, 32'hFFFF_FFFF);
      settle();

      // Random phases alternate between filling, mixing and draining the table. The
      // second phase starts with a long receiver hold-off while requests keep coming,
      // and the fifth runs with no gaps or stalls at all. Between phases the sender
      // waits until every response has come back.
      for (p = 0; p < 6; p++) begin
         idle_on = (p != 4);
         if (p == 1) hold_request = 150;
         for (i = 0; i < 75; i++) send_request(random_request(mix_kind'(p % 3)), pick_pause());
         settle();
      end

      idle_on = 1'b0;
      repeat (40) @(posedge clock);
      if (ledger.failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Guards against a hung handshake: far beyond the slowest correct run.
   initial begin : watchdog
      #4_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
